// ----- sv/binned_mean_accumulator_unit_macros.svh -----
// Assertion macros shared by the binned mean accumulator RTL.
`ifndef BINNED_MEAN_ACCUMULATOR_UNIT_MACROS_SVH
`define BINNED_MEAN_ACCUMULATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define BMA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bma: same-cycle check failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define BMA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bma: next-cycle check failed");

`endif

// ----- sv/bma_pkg.sv -----
// Types, constants and defaults of the binned mean accumulator.
package bma_pkg;

    localparam int unsigned BINS_DEFAULT      = 32768;
    localparam int unsigned SAMPLE_W_DEFAULT  = 32;
    localparam int unsigned COUNT_W_DEFAULT   = 16;
    localparam int unsigned SUM_WIDTH         = 48;

    localparam int unsigned SAMPLE_FIELD_W    = 32;
    localparam int unsigned INDEX_FIELD_W     = 32;
    localparam int unsigned MEAN_W            = 32;
    localparam int unsigned HITS_W            = 16;
    localparam int unsigned BIN_NUM_W         = 15;
    localparam int unsigned CFG_W             = 16;

    localparam logic [CFG_W-1:0] ACTIVE_BINS_RESET = 16'd27664;

    localparam logic OP_ACCUM = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic                              op;
        logic signed [SAMPLE_FIELD_W-1:0]  sample;
        logic signed [INDEX_FIELD_W-1:0]   bin_index;
    } t_in_word;

    typedef struct packed {
        logic signed [MEAN_W-1:0]  bin_mean;
        logic [HITS_W-1:0]         hit_count;
        logic [BIN_NUM_W-1:0]      bin_number;
    } t_out_word;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ----- sv/bma_bin_mem.sv -----
// Bin store: one-write, one-read synchronous RAM holding {sum, hits} per bin.
module bma_bin_mem
    import bma_pkg::*;
#(
    parameter int unsigned DEPTH  = BINS_DEFAULT,
    parameter int unsigned DATA_W = SUM_WIDTH + COUNT_W_DEFAULT
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]        o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/bma_div.sv -----
// Radix-2 restoring divider: signed sum by unsigned nonzero count, truncating.
module bma_div
    import bma_pkg::*;
#(
    parameter int unsigned DIVISOR_W = COUNT_W_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic signed [SUM_WIDTH-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]        i_divisor,
    output t_div_stat                   o_stat,
    output logic signed [SUM_WIDTH-1:0] o_quotient
);

    localparam int unsigned CntW = $clog2(SUM_WIDTH + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CntW-1:0]      r_cnt;
    logic [DIVISOR_W-1:0] r_rem;
    logic [SUM_WIDTH-1:0] r_quo;
    logic [DIVISOR_W-1:0] r_div;
    logic                 r_neg;

    logic [DIVISOR_W:0]   w_trial;
    logic [DIVISOR_W:0]   w_diff;
    logic                 w_fit;
    logic [SUM_WIDTH-1:0] w_mag;

    // shift one dividend bit into the partial remainder per cycle
    assign w_trial = {r_rem, r_quo[SUM_WIDTH-1]};
    assign w_fit   = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_mag   = i_dividend[SUM_WIDTH-1] ? $unsigned(-i_dividend) : $unsigned(i_dividend);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(SUM_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CntW'(1);
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= w_mag;
            r_rem <= '0;
            r_div <= i_divisor;
            r_neg <= i_dividend[SUM_WIDTH-1];
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[DIVISOR_W-1:0] : w_trial[DIVISOR_W-1:0];
            r_quo <= {r_quo[SUM_WIDTH-2:0], w_fit};
        end
    end

    // restore the sign: truncation toward zero
    assign o_quotient  = r_neg ? -$signed(r_quo) : $signed(r_quo);
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// ----- sv/binned_mean_accumulator_unit.sv -----
// Binned mean accumulator top level: control sequencer, bin store, divider.
// Accumulate word: the bin is read on accept and written back in S_RMW, then the next word is accepted.
// Nonempty readout: the 48-step serial divider runs in S_DIV, then S_OUT registers the result;
// empty or out-of-range readout: S_RMW goes straight to S_OUT. A held result word stalls S_OUT
// and so delays a following readout. One word in flight.
// Reset: synchronous, active low; a clearing pass then zeroes all bins.
`include "binned_mean_accumulator_unit_macros.svh"

module binned_mean_accumulator_unit
    import bma_pkg::*;
#(
    parameter int unsigned NUM_BINS     = BINS_DEFAULT,
    parameter int unsigned SAMPLE_WIDTH = SAMPLE_W_DEFAULT,
    parameter int unsigned COUNT_WIDTH  = COUNT_W_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input words
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_word          i_in_word,
    // result words
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_word         o_out_word,
    // active_bins register write
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    localparam int unsigned IdxW = $clog2(NUM_BINS);
    localparam int unsigned MemW = SUM_WIDTH + COUNT_WIDTH;

    // one-hot sequencer states
    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_RMW   = 5'b00100,
        S_DIV   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [CFG_W-1:0]            r_active_bins;
    logic [IdxW-1:0]             r_clr_addr;

    // captured item
    logic                        r_op;
    logic                        r_hit;
    logic [IdxW-1:0]             r_addr;
    logic signed [SUM_WIDTH-1:0] r_sample_ext;
    logic [BIN_NUM_W-1:0]        r_bin_number;

    // pending readout result
    logic [COUNT_WIDTH-1:0]      r_res_hits;
    logic signed [MEAN_W-1:0]    r_res_mean;

    logic                        r_out_valid;
    t_out_word                   r_out_word;

    // bin store ports
    logic                        mem_rd_en;
    logic [MemW-1:0]             mem_rd_data;
    logic                        mem_wr_en;
    logic [IdxW-1:0]             mem_wr_addr;
    logic [MemW-1:0]             mem_wr_data;

    // divider ports
    logic                        div_start;
    logic [COUNT_WIDTH-1:0]      div_divisor;
    t_div_stat                   div_stat;
    logic signed [SUM_WIDTH-1:0] div_quotient;
    logic                        div_done;

    logic                        in_accept;
    logic                        in_range;
    logic [INDEX_FIELD_W-1:0]    in_idx;
    logic [SUM_WIDTH-1:0]        in_sample_zx;
    logic signed [SAMPLE_WIDTH-1:0] in_sample_trunc;
    logic signed [SUM_WIDTH-1:0] rd_sum;
    logic [COUNT_WIDTH-1:0]      rd_hits;
    logic                        rd_sat;
    logic                        load_out;

    // ---------------------------------------------------------------
    // Handshakes. Input is taken only in S_IDLE; the output register
    // decouples result delivery so the next item can start meanwhile.
    // ---------------------------------------------------------------
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Range check: nonnegative, below active_bins and below NUM_BINS.
    assign in_idx   = $unsigned(i_in_word.bin_index);
    assign in_range = !in_idx[INDEX_FIELD_W-1]
                      && (in_idx < INDEX_FIELD_W'(r_active_bins))
                      && (in_idx < INDEX_FIELD_W'(NUM_BINS));

    // Sample: take the low SAMPLE_WIDTH bits of the field and sign-extend.
    assign in_sample_zx    = SUM_WIDTH'($unsigned(i_in_word.sample));
    assign in_sample_trunc = $signed(in_sample_zx[SAMPLE_WIDTH-1:0]);

    // Split the entry read on accept: {sum, hits}.
    assign rd_sum  = $signed(mem_rd_data[MemW-1:COUNT_WIDTH]);
    assign rd_hits = mem_rd_data[COUNT_WIDTH-1:0];
    assign rd_sat  = &rd_hits;

    // Read the addressed bin as the word is accepted; the data lands for S_RMW.
    assign mem_rd_en = in_accept;

    // Write port: clearing sweep, or the write-back of the captured item.
    // Only one item is in flight, so a read never overlaps a pending write
    // to the same bin and no forwarding path is needed.
    always_comb begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_addr;
        mem_wr_data = '0;
        unique case (r_state)
            S_CLEAR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_clr_addr;
            end
            S_RMW: begin
                if (r_op == OP_ACCUM) begin
                    // drop the sample when the bin is out of range or saturated
                    mem_wr_en   = r_hit && !rd_sat;
                    mem_wr_data = {rd_sum + r_sample_ext, rd_hits + COUNT_WIDTH'(1)};
                end else begin
                    // readout clears the bin
                    mem_wr_en = r_hit;
                end
            end
            S_IDLE, S_DIV, S_OUT: begin
                mem_wr_en = 1'b0;
            end
            default: begin
                mem_wr_en = 1'b0;
            end
        endcase
    end

    // Start the divider only for a nonempty in-range readout.
    assign div_start   = (r_state == S_RMW) && (r_op == OP_READ) && r_hit && (rd_hits != '0);
    assign div_divisor = rd_hits;
    assign div_done    = div_stat.done;

    assign load_out = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == IdxW'(NUM_BINS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_RMW;
                end
            end
            S_RMW: begin
                priority if (r_op == OP_ACCUM) begin
                    n_state = S_IDLE;
                end else if (div_start) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_addr    <= '0;
            r_active_bins <= ACTIVE_BINS_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + IdxW'(1);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_active_bins <= i_cfg_data;
            end
            // hold the result until it is taken
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: capture the item, the pending result and the output.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op         <= i_in_word.op;
            r_hit        <= in_range;
            r_addr       <= i_in_word.bin_index[IdxW-1:0];
            r_sample_ext <= SUM_WIDTH'(in_sample_trunc);
            r_bin_number <= i_in_word.bin_index[BIN_NUM_W-1:0];
        end
        if (r_state == S_RMW) begin
            r_res_hits <= r_hit ? rd_hits : '0;
            r_res_mean <= '0;
        end
        if (div_done) begin
            r_res_mean <= div_quotient[MEAN_W-1:0];
        end
        if (load_out) begin
            r_out_word.bin_mean   <= r_res_mean;
            r_out_word.hit_count  <= HITS_W'(r_res_hits);
            r_out_word.bin_number <= r_bin_number;
        end
    end

    // ---------------------------------------------------------------
    // Submodules
    // ---------------------------------------------------------------
    bma_bin_mem #(
        .DEPTH  (NUM_BINS),
        .DATA_W (MemW)
    ) u_bin_mem (
        .i_clk     (i_clk),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (i_in_word.bin_index[IdxW-1:0]),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data)
    );

    bma_div #(
        .DIVISOR_W (COUNT_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (rd_sum),
        .i_divisor  (div_divisor),
        .o_stat     (div_stat),
        .o_quotient (div_quotient)
    );

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `BMA_ASSERT_NOW(a_no_rd_wr_overlap, mem_wr_en, !mem_rd_en)
    `BMA_ASSERT_NOW(a_div_start_idle, div_start, !div_stat.busy && (div_divisor != '0))
    `BMA_ASSERT_NEXT(a_div_done_to_out, div_done, r_state == S_OUT)
    `BMA_ASSERT_NOW(a_out_from_s_out, $rose(r_out_valid), $past(r_state) == S_OUT)

endmodule

// ----- tb/bin_mean_checker.sv -----
`timescale 1ns / 1ps
// Result checker for the binned mean accumulator: tracks bin state and compares readouts.
module bin_mean_checker
    import bma_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  t_in_word          i_in_word,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  t_out_word         i_out_word,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_data,
    output int                o_errors,
    output int                o_pending
);

    localparam int unsigned NUM_BINS = BINS_DEFAULT;
    localparam logic [COUNT_W_DEFAULT-1:0] HIT_MAX = '1;

    logic [SUM_WIDTH-1:0]       bin_sum  [NUM_BINS];
    logic [COUNT_W_DEFAULT-1:0] bin_hits [NUM_BINS];
    logic [CFG_W-1:0]           active_bins;
    t_out_word                  expected_means [$];
    int                         errors;

    initial begin
        active_bins = ACTIVE_BINS_RESET;
        for (int i = 0; i < NUM_BINS; i++) begin
            bin_sum[i]  = '0;
            bin_hits[i] = '0;
        end
        errors    = 0;
        o_errors  = 0;
        o_pending = 0;
    end

    // Update bin state for one accepted input word; queue the readout it causes.
    task automatic apply_word(input t_in_word w);
        bit          in_range;
        int unsigned b;
        longint      sum;
        t_out_word   r;
        in_range = longint'(w.bin_index) >= 0 &&
                   longint'(w.bin_index) < longint'(active_bins) &&
                   longint'(w.bin_index) < longint'(NUM_BINS);
        b = in_range ? int'(w.bin_index) : 0;
        if (w.op == OP_ACCUM) begin
            if (in_range && bin_hits[b] != HIT_MAX) begin
                bin_sum[b]  = bin_sum[b] +
                              {{(SUM_WIDTH-SAMPLE_FIELD_W){w.sample[SAMPLE_FIELD_W-1]}}, w.sample};
                bin_hits[b] = bin_hits[b] + 1'b1;
            end
        end else begin
            r.bin_mean   = '0;
            r.hit_count  = '0;
            r.bin_number = w.bin_index[BIN_NUM_W-1:0];
            if (in_range) begin
                r.hit_count = bin_hits[b];
                if (bin_hits[b] != 0) begin
                    // signed division truncates toward zero
                    sum        = longint'($signed(bin_sum[b]));
                    r.bin_mean = MEAN_W'(sum / longint'(bin_hits[b]));
                end
                bin_sum[b]  = '0;
                bin_hits[b] = '0;
            end
            expected_means.push_back(r);
        end
    endtask

    task automatic field_mismatch(input string name, input longint want, input longint got);
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    endtask

    task automatic check_readout(input t_out_word got);
        t_out_word want;
        if (expected_means.size() == 0) begin
            errors++;
            $display("%0t: result word with nothing expected, expected none, actual %h",
                     $time, got);
        end else begin
            want = expected_means.pop_front();
            if (got.bin_mean !== want.bin_mean)
                field_mismatch("bin_mean", want.bin_mean, got.bin_mean);
            if (got.hit_count !== want.hit_count)
                field_mismatch("hit_count", want.hit_count, got.hit_count);
            if (got.bin_number !== want.bin_number)
                field_mismatch("bin_number", want.bin_number, got.bin_number);
        end
    endtask

    // A word accepted at the same edge as a register write still sees the old bin count.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall)
                check_readout(i_out_word);
            if (i_in_valid && !i_in_stall)
                apply_word(i_in_word);
            if (i_cfg_valid && i_cfg_ready)
                active_bins = i_cfg_data;
        end
        o_pending = expected_means.size();
        o_errors  = errors;
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Top of the binned mean accumulator testbench: stimulus, receiver stalls and verdict.
module testbench;
    import bma_pkg::*;

    // Generous cap on the run length.
    localparam int CYCLE_LIMIT  = 1_000_000;
    // Quiet time after the last readout, covering an accumulate still in flight.
    localparam int SETTLE       = 60;
    localparam int PHASE_ITEMS  = 105;
    localparam int LONG_HOLD    = 400;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    t_in_word           in_word;
    logic               out_valid;
    logic               out_stall;
    t_out_word          out_word;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_data;

    int                 errors;
    int                 pending;
    int                 cycle_count;
    bit                 gaps_on;
    bit                 long_hold_req;
    logic [CFG_W-1:0]   active_now;

    binned_mean_accumulator_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    bin_mean_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_word   (in_word),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Abort a hung run.
    initial cycle_count = 0;
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: mix open stretches, short stalls and a few long ones.
    // A long hold-off on request lets the block back up and stall its input.
    initial begin : receiver
        int left;
        int r;
        logic level;
        left  = 0;
        level = 1'b0;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                level = 1'b1;
                left  = LONG_HOLD;
            end else if (left == 0) begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    level = 1'b0;
                    left  = $urandom_range(5, 40);
                end else if (r < 85) begin
                    level = 1'b1;
                    left  = $urandom_range(0, 3);
                end else if (r < 95) begin
                    level = 1'b0;
                    left  = $urandom_range(0, 3);
                end else begin
                    level = 1'b1;
                    left  = $urandom_range(10, 40);
                end
            end else begin
                left--;
            end
            out_stall <= level;
        end
    end

    function automatic t_in_word make_word(input logic op, input logic [31:0] sample,
                                           input logic [31:0] idx);
        t_in_word w;
        w.op        = op;
        w.sample    = sample;
        w.bin_index = idx;
        return w;
    endfunction

    // Offer one word, optionally after an idle gap, and hold it until accepted.
    // Valid is only dropped when a gap follows, so it never toggles within a step.
    task automatic send_word(input t_in_word w);
        int gap;
        int r;
        gap = 0;
        if (gaps_on) begin
            r = $urandom_range(0, 99);
            if (r < 60)
                gap = 0;
            else if (r < 90)
                gap = $urandom_range(1, 3);
            else
                gap = $urandom_range(8, 30);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
    endtask

    // Stop sending and hold until every readout has returned, then let any
    // trailing accumulate finish.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Random traffic: most words hit a few hot bins so sums build up before
    // readouts; the rest probe the range edges and arbitrary indices.
    task automatic run_random(input int target);
        int       counted;
        int       r;
        t_in_word w;
        counted = 0;
        while (counted < target) begin
            w.op = ($urandom_range(0, 99) < 30) ? OP_READ : OP_ACCUM;
            r = $urandom_range(0, 99);
            if (r < 65)
                w.sample = $urandom();
            else if (r < 75)
                w.sample = 32'h7FFF_FFFF;
            else if (r < 85)
                w.sample = 32'h8000_0000;
            else
                w.sample = int'($urandom_range(0, 2000)) - 1000;
            r = $urandom_range(0, 99);
            if (r < 55)
                w.bin_index = $urandom_range(0, 7);
            else if (r < 70)
                w.bin_index = int'(active_now) - 1 - int'($urandom_range(0, 2));
            else if (r < 80)
                w.bin_index = int'(active_now) + int'($urandom_range(0, 2));
            else if (r < 88)
                w.bin_index = 32767 + int'($urandom_range(0, 1));
            else
                w.bin_index = $urandom();
            send_word(w);
            counted++;
        end
    endtask

    initial begin : stimulus
        logic [CFG_W-1:0] phase_bins [5];
        in_valid      <= 1'b0;
        in_word       <= '0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        rst_n         <= 1'b0;
        gaps_on       = 1'b1;
        long_hold_req = 1'b0;
        active_now    = ACTIVE_BINS_RESET;
        phase_bins[0] = 16'd1;
        phase_bins[1] = 16'd0;
        phase_bins[2] = 16'hFFFF;
        phase_bins[3] = 16'd32768;
        phase_bins[4] = 16'($urandom_range(1, 32768));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words under the reset bin count; the block stalls them
        // until its clearing pass is over.
        // Extreme positive samples.
        send_word(make_word(OP_ACCUM, 32'h7FFF_FFFF, 0));
        send_word(make_word(OP_ACCUM, 32'h7FFF_FFFF, 0));
        send_word(make_word(OP_READ,  32'h0,         0));
        // Extreme negative samples.
        send_word(make_word(OP_ACCUM, 32'h8000_0000, 1));
        send_word(make_word(OP_ACCUM, 32'h8000_0000, 1));
        send_word(make_word(OP_READ,  32'hFFFF_FFFF, 1));
        // Negative means truncate toward zero, not down.
        send_word(make_word(OP_ACCUM, -1, 2));
        send_word(make_word(OP_ACCUM, -1, 2));
        send_word(make_word(OP_ACCUM, 0,  2));
        send_word(make_word(OP_READ,  0,  2));
        send_word(make_word(OP_ACCUM, -7, 3));
        send_word(make_word(OP_ACCUM, 2,  3));
        send_word(make_word(OP_READ,  0,  3));
        // Empty bin.
        send_word(make_word(OP_READ,  32'h1234_5678, 4));
        // Last active bin, then the first one past it.
        send_word(make_word(OP_ACCUM, 100, int'(ACTIVE_BINS_RESET) - 1));
        send_word(make_word(OP_READ,  0,   int'(ACTIVE_BINS_RESET) - 1));
        send_word(make_word(OP_ACCUM, 5,   int'(ACTIVE_BINS_RESET)));
        send_word(make_word(OP_READ,  0,   int'(ACTIVE_BINS_RESET)));
        // Negative and extreme indices.
        send_word(make_word(OP_ACCUM, 5, 32'hFFFF_FFFF));
        send_word(make_word(OP_READ,  0, 32'hFFFF_FFFF));
        send_word(make_word(OP_READ,  0, 32'h8000_0000));
        send_word(make_word(OP_READ,  0, 32'h7FFF_FFFF));
        // A bin read twice comes back cleared.
        send_word(make_word(OP_READ,  0, 0));

        // Back the block up behind a long receiver hold-off.
        long_hold_req = 1'b1;
        run_random(PHASE_ITEMS);

        for (int p = 0; p < 5; p++) begin
            wait_for_results();
            cfg_valid <= 1'b1;
            cfg_data  <= phase_bins[p];
            do @(posedge clk); while (!cfg_ready);
            cfg_valid  <= 1'b0;
            active_now = phase_bins[p];
            gaps_on    = (p != 2);
            run_random(PHASE_ITEMS);
        end

        wait_for_results();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
